// File: rtl/edge_list_table_unit_assert.svh
// assertion macros for the edge list table unit
`ifndef EDGE_LIST_TABLE_UNIT_ASSERT_SVH
`define EDGE_LIST_TABLE_UNIT_ASSERT_SVH
`ifndef SYNTH
`define ELT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ELT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ELT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define ELT_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/elt_pkg.sv
package elt_pkg;

    localparam int MaxNodes = 64;
    localparam int MaxEdges = 256;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NEIGH  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_NODE = 3'd1,
        ST_NO_EDGE  = 3'd2,
        ST_FULL     = 3'd3,
        ST_REVERSED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN_REQ,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_LIST,
        S_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture input item
        logic do_insert;   // write entry at count, bump count
        logic scan_start;  // clear scan index and flags
        logic scan_rd;     // issue read at scan index
        logic scan_chk;    // evaluate read data, step index
        logic shift_rd;    // read entry idx+1
        logic shift_wr;    // write it at idx, step
        logic shift_done;  // drop count
        logic list_start;  // clear node index
        logic list_step;   // step node index
        logic emit;        // load output register
        logic emit_last;
        logic emit_nb;     // output holds a neighbour
        logic [2:0] emit_status;
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic bad_a;
        logic bad_ab;
        logic full;
        logic scan_end;     // index reached count
        logic hit_exact;
        logic hit_any;
        logic rev_seen;
        logic shift_end;
        logic nb_here;      // current node is a neighbour
        logic nb_more;      // another neighbour above current
        logic out_busy;     // output register full and not taken
    } sts_t;

endpackage

// File: rtl/elt_ctrl.sv
module elt_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_fire,
    input  elt_pkg::sts_t sts,
    output elt_pkg::ctl_t ctl,
    output logic          idle
);

    elt_pkg::state_t state_reg;
    elt_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= elt_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            elt_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = elt_pkg::S_DECIDE;
                end
            end
            elt_pkg::S_DECIDE:
            begin
                if (sts.op == elt_pkg::OP_INSERT)
                begin
                    state_next = elt_pkg::S_OUT;
                end
                else if (sts.op == elt_pkg::OP_NEIGH && sts.bad_a)
                begin
                    state_next = elt_pkg::S_OUT;
                end
                else
                begin
                    state_next = elt_pkg::S_SCAN_REQ;
                end
            end
            elt_pkg::S_SCAN_REQ:
            begin
                if (sts.scan_end)
                begin
                    state_next = (sts.op == elt_pkg::OP_NEIGH) ? elt_pkg::S_LIST
                                                                : elt_pkg::S_OUT;
                end
                else
                begin
                    state_next = elt_pkg::S_SCAN_CHK;
                end
            end
            elt_pkg::S_SCAN_CHK:
            begin
                if (sts.op == elt_pkg::OP_REMOVE && sts.hit_exact)
                begin
                    state_next = elt_pkg::S_SHIFT_RD;
                end
                else if (sts.op == elt_pkg::OP_QUERY && sts.hit_any)
                begin
                    state_next = elt_pkg::S_OUT;
                end
                else
                begin
                    state_next = elt_pkg::S_SCAN_REQ;
                end
            end
            elt_pkg::S_SHIFT_RD:
            begin
                state_next = sts.shift_end ? elt_pkg::S_OUT : elt_pkg::S_SHIFT_WR;
            end
            elt_pkg::S_SHIFT_WR:
            begin
                state_next = elt_pkg::S_SHIFT_RD;
            end
            elt_pkg::S_LIST:
            begin
                if (!sts.out_busy)
                begin
                    if (!sts.nb_more)
                    begin
                        state_next = elt_pkg::S_IDLE;
                    end
                    else if (sts.nb_here && !sts.out_busy)
                    begin
                        state_next = elt_pkg::S_LIST;
                    end
                end
            end
            elt_pkg::S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    state_next = elt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = elt_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        ctl = '0;
        idle = 1'b0;
        case (state_reg)
            elt_pkg::S_IDLE:
            begin
                idle = 1'b1;
                ctl.load = in_fire;
            end
            elt_pkg::S_DECIDE:
            begin
                ctl.scan_start = 1'b1;
                ctl.list_start = 1'b1;
            end
            elt_pkg::S_SCAN_REQ:
            begin
                ctl.scan_rd = !sts.scan_end;
            end
            elt_pkg::S_SCAN_CHK:
            begin
                ctl.scan_chk = 1'b1;
            end
            elt_pkg::S_SHIFT_RD:
            begin
                ctl.shift_rd = !sts.shift_end;
                ctl.shift_done = sts.shift_end;
            end
            elt_pkg::S_SHIFT_WR:
            begin
                ctl.shift_wr = 1'b1;
            end
            elt_pkg::S_LIST:
            begin
                // one node per cycle unless busy; emit neighbours
                if (!sts.out_busy)
                begin
                    ctl.list_step = 1'b1;
                    if (sts.nb_here)
                    begin
                        ctl.emit = 1'b1;
                        ctl.emit_nb = 1'b1;
                        ctl.emit_last = !sts.nb_more;
                        ctl.emit_status = elt_pkg::ST_OK;
                    end
                    else if (!sts.nb_more)
                    begin
                        ctl.emit = 1'b1;
                        ctl.emit_last = 1'b1;
                        ctl.emit_status = elt_pkg::ST_OK;
                    end
                end
            end
            elt_pkg::S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    ctl.emit = 1'b1;
                    ctl.emit_last = 1'b1;
                    ctl.do_insert = (sts.op == elt_pkg::OP_INSERT) && !sts.bad_ab
                                    && !sts.full;
                    case (sts.op)
                        elt_pkg::OP_INSERT:
                            ctl.emit_status = sts.bad_ab ? elt_pkg::ST_BAD_NODE :
                                              sts.full ? elt_pkg::ST_FULL : elt_pkg::ST_OK;
                        elt_pkg::OP_REMOVE:
                            ctl.emit_status = sts.hit_exact ? elt_pkg::ST_OK :
                                              sts.rev_seen ? elt_pkg::ST_REVERSED
                                                           : elt_pkg::ST_NO_EDGE;
                        elt_pkg::OP_NEIGH:
                            ctl.emit_status = elt_pkg::ST_BAD_NODE;
                        default:
                            ctl.emit_status = elt_pkg::ST_OK;
                    endcase
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

// File: rtl/elt_dpath.sv
`include "edge_list_table_unit_assert.svh"
module elt_dpath
#(
    parameter int MAX_NODES = elt_pkg::MaxNodes,
    parameter int MAX_EDGES = elt_pkg::MaxEdges
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  elt_pkg::ctl_t ctl,
    output elt_pkg::sts_t sts,
    input  logic [6:0]    node_count,
    input  logic [37:0]   in_data,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [20:0]   out_data
);

    localparam int AW = $clog2(MAX_EDGES);
    localparam int CW = $clog2(MAX_EDGES + 1);

    // item registers
    logic [1:0]  op_reg;
    logic [5:0]  a_reg;
    logic [5:0]  b_reg;
    logic [23:0] pay_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] idx_reg;
    logic        exact_reg;
    logic        rev_reg;
    logic        any_reg;
    logic        rdv_reg;
    logic [63:0] adj_reg;
    logic [6:0]  node_reg;
    logic [35:0] rd_reg;
    logic [35:0] mem [MAX_EDGES];
    logic        ov_reg;
    logic [20:0] od_reg;

    logic [6:0] lim;
    logic       cur_exact;
    logic       cur_rev;
    logic [63:0] nb_mask;
    logic [63:0] above;
    logic [63:0] adj_add;
    logic [5:0]  rd_a;
    logic [5:0]  rd_b;

    assign lim = (node_count > 7'(MAX_NODES)) ? 7'(MAX_NODES) : node_count;
    assign rd_a = rd_reg[35:30];
    assign rd_b = rd_reg[29:24];
    assign cur_exact = rdv_reg && rd_a == a_reg && rd_b == b_reg;
    assign cur_rev = rdv_reg && rd_a == b_reg && rd_b == a_reg;

    // neighbour mask: below limit, not self
    always_comb
    begin
        for (int j = 0; j < 64; j++)
        begin
            nb_mask[j] = adj_reg[j] && (7'(j) < lim) && (6'(j) != a_reg);
            above[j] = nb_mask[j] && (7'(j) > node_reg);
        end
    end

    // adjacency bits contributed by the entry just read
    always_comb
    begin
        adj_add = '0;
        if (rd_a == a_reg)
        begin
            adj_add[rd_b] = 1'b1;
        end
        if (rd_b == a_reg)
        begin
            adj_add[rd_a] = 1'b1;
        end
    end

    // edge memory
    always_ff @(posedge clk)
    begin
        if (ctl.do_insert)
        begin
            mem[cnt_reg[AW-1:0]] <= {a_reg, b_reg, pay_reg};
        end
        else if (ctl.shift_wr)
        begin
            mem[idx_reg[AW-1:0]] <= rd_reg;
        end
        if (ctl.scan_rd)
        begin
            rd_reg <= mem[idx_reg[AW-1:0]];
        end
        else if (ctl.shift_rd)
        begin
            rd_reg <= mem[AW'(idx_reg + 1'b1)];
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            op_reg  <= in_data[1:0];
            a_reg   <= in_data[7:2];
            b_reg   <= in_data[13:8];
            pay_reg <= in_data[37:14];
        end
    end

    // scan and list control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
            exact_reg <= 1'b0;
            rev_reg <= 1'b0;
            any_reg <= 1'b0;
            rdv_reg <= 1'b0;
            adj_reg <= '0;
            node_reg <= '0;
        end
        else
        begin
            rdv_reg <= ctl.scan_rd;
            if (ctl.scan_start)
            begin
                idx_reg <= '0;
                exact_reg <= 1'b0;
                rev_reg <= 1'b0;
                any_reg <= 1'b0;
                adj_reg <= '0;
            end
            if (ctl.scan_chk)
            begin
                // only a remove stops on its exact match
                if (cur_exact && op_reg == elt_pkg::OP_REMOVE)
                begin
                    exact_reg <= 1'b1;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (cur_rev && !cur_exact)
                begin
                    rev_reg <= 1'b1;
                end
                if (cur_exact || cur_rev)
                begin
                    any_reg <= 1'b1;
                end
                adj_reg <= adj_reg | adj_add;
            end
            if (ctl.shift_wr)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (ctl.shift_done)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (ctl.do_insert)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (ctl.list_start)
            begin
                node_reg <= '0;
            end
            if (ctl.list_step)
            begin
                node_reg <= node_reg + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (ctl.emit)
        begin
            ov_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_reg <= 1'b0;
        end
    end

    // a found remove has already dropped the count before its result is loaded
    always_ff @(posedge clk)
    begin
        if (ctl.emit)
        begin
            od_reg[2:0] <= ctl.emit_status;
            od_reg[3] <= (op_reg == elt_pkg::OP_QUERY) && any_reg;
            od_reg[9:4] <= ctl.emit_nb ? node_reg[5:0] : 6'd0;
            od_reg[10] <= ctl.emit_nb;
            od_reg[11] <= ctl.emit_last;
            od_reg[20:12] <= ctl.do_insert ? 9'(cnt_reg + 1'b1) : 9'(cnt_reg);
        end
    end

    // status to controller
    always_comb
    begin
        sts.op = op_reg;
        sts.bad_a = {1'b0, a_reg} >= lim;
        sts.bad_ab = ({1'b0, a_reg} >= lim) || ({1'b0, b_reg} >= lim);
        sts.full = cnt_reg >= CW'(MAX_EDGES);
        sts.scan_end = idx_reg >= cnt_reg;
        sts.hit_exact = exact_reg || cur_exact;
        sts.hit_any = cur_exact || cur_rev;
        sts.rev_seen = rev_reg;
        sts.shift_end = (idx_reg + 1'b1) >= cnt_reg;
        sts.nb_here = node_reg < 7'd64 && nb_mask[node_reg[5:0]];
        sts.nb_more = |above;
        sts.out_busy = ov_reg && !out_ready;
    end

    assign out_valid = ov_reg;
    assign out_data = od_reg;

    `ELT_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, cnt_reg <= CW'(MAX_EDGES))
    `ELT_ASSERT_NEXT(a_ins_cnt, clk, rst_n, ctl.do_insert, cnt_reg == $past(cnt_reg) + 1'b1)
    `ELT_ASSERT_IMP(a_emit_free, clk, rst_n, ctl.emit, !(ov_reg && !out_ready))

endmodule

// File: rtl/edge_list_table_unit.sv
// edge list table unit: insert, remove, query and neighbour listing
// insert skips the scan; remove shifts the entries after its match down; query stops at a hit
// neighbours: a full scan, then one node per cycle up to the highest neighbour unless stalled
// one item at a time; the scan reads, then checks, each entry in turn
// reset: asynchronous active low clears edge count, control and node_count to 64
module edge_list_table_unit
#(
    parameter int MAX_NODES = elt_pkg::MaxNodes,
    parameter int MAX_EDGES = elt_pkg::MaxEdges
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // op, node_a, node_b, edge_tag, years_value, zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // status, found, neighbour, neighbour_valid, edge_count, pad
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    elt_pkg::ctl_t ctl;
    elt_pkg::sts_t sts;
    logic          idle;
    logic [6:0]    node_count_reg;
    logic [20:0]   od;

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= 7'd64;
        end
        else if (psel && penable && pwrite && paddr == 2'd0)
        begin
            node_count_reg <= pwdata[6:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {25'd0, node_count_reg} : 32'd0;

    assign s_tready = idle;

    elt_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (s_tvalid && s_tready),
        .sts     (sts),
        .ctl     (ctl),
        .idle    (idle)
    );

    elt_dpath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dpath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .sts        (sts),
        .node_count (node_count_reg),
        .in_data    (s_tdata[37:0]),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_data   (od)
    );

    // output packing, last travels separately
    assign m_tdata = {4'd0, od[20:12], od[10:0]};
    assign m_tlast = od[11];

endmodule

// File: verif/edge_list_table_unit_tb.sv
`timescale 1ns / 1ps

module edge_list_table_unit_tb;

    localparam int WATCHDOG_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 1200;
    localparam logic [1:0] REG_NODE_COUNT = 2'd0;

    typedef struct {
        logic [2:0] status;
        logic       found;
        logic [5:0] neighbour;
        logic       nb_valid;
        logic       last;
        logic [8:0] edge_count;
    } result_t;

    typedef struct {
        logic [5:0]  a;
        logic [5:0]  b;
        logic [15:0] tag;
        logic [7:0]  years;
    } edge_t;

    // shadow of the edge table; predicts the results of each operation
    class edge_table_sb;
        edge_t   edges[$];
        int      node_lim;
        result_t pending[$];
        int      errors;
        int      checked;

        function new();
            node_lim = 64;
            errors = 0;
            checked = 0;
        endfunction

        function void set_node_count(logic [6:0] v);
            node_lim = (v > elt_pkg::MaxNodes) ? elt_pkg::MaxNodes : int'(v);
        endfunction

        function void push(logic [2:0] st, logic f, logic [5:0] nb, logic v, logic l);
            result_t r;
            r.status = st;
            r.found = f;
            r.neighbour = nb;
            r.nb_valid = v;
            r.last = l;
            r.edge_count = 9'(edges.size());
            pending.push_back(r);
        endfunction

        function void note_op(elt_pkg::op_t op, logic [5:0] a, logic [5:0] b,
                              logic [15:0] tag, logic [7:0] years);
            edge_t e;
            logic [2:0] st;
            logic [63:0] adj;
            int pos;
            int nbs[$];
            st = elt_pkg::ST_OK;
            pos = -1;
            adj = '0;
            case (op)
                elt_pkg::OP_INSERT:
                begin
                    if (a >= node_lim || b >= node_lim) st = elt_pkg::ST_BAD_NODE;
                    else if (edges.size() >= elt_pkg::MaxEdges) st = elt_pkg::ST_FULL;
                    else
                    begin
                        e.a = a; e.b = b; e.tag = tag; e.years = years;
                        edges.push_back(e);
                    end
                    push(st, 1'b0, 6'd0, 1'b0, 1'b1);
                end
                elt_pkg::OP_REMOVE:
                begin
                    st = elt_pkg::ST_NO_EDGE;
                    foreach (edges[i])
                    begin
                        if (pos < 0)
                        begin
                            if (edges[i].a == a && edges[i].b == b) pos = i;
                            else if (edges[i].a == b && edges[i].b == a)
                                st = elt_pkg::ST_REVERSED;
                        end
                    end
                    if (pos >= 0)
                    begin
                        edges.delete(pos);
                        st = elt_pkg::ST_OK;
                    end
                    push(st, 1'b0, 6'd0, 1'b0, 1'b1);
                end
                elt_pkg::OP_QUERY:
                begin
                    foreach (edges[i])
                        if ((edges[i].a == a && edges[i].b == b) ||
                            (edges[i].a == b && edges[i].b == a)) pos = i;
                    push(elt_pkg::ST_OK, pos >= 0, 6'd0, 1'b0, 1'b1);
                end
                default:
                begin
                    if (a >= node_lim) push(elt_pkg::ST_BAD_NODE, 1'b0, 6'd0, 1'b0, 1'b1);
                    else
                    begin
                        foreach (edges[i])
                        begin
                            if (edges[i].a == a) adj[edges[i].b] = 1'b1;
                            if (edges[i].b == a) adj[edges[i].a] = 1'b1;
                        end
                        for (int j = 0; j < node_lim; j++)
                            if (j != a && adj[j]) nbs.push_back(j);
                        if (nbs.size() == 0) push(elt_pkg::ST_OK, 1'b0, 6'd0, 1'b0, 1'b1);
                        foreach (nbs[j])
                            push(elt_pkg::ST_OK, 1'b0, 6'(nbs[j]), 1'b1,
                                 j == nbs.size() - 1);
                    end
                end
            endcase
        endfunction

        function void check(logic [23:0] data, logic tlast);
            result_t x;
            checked++;
            if (pending.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected transaction data=%h last=%b", $time, data, tlast);
                return;
            end
            x = pending.pop_front();
            if (data[2:0] !== x.status || data[3] !== x.found || data[9:4] !== x.neighbour
                || data[10] !== x.nb_valid || data[19:11] !== x.edge_count
                || tlast !== x.last)
            begin
                errors++;
                $display("%0t: expected st=%0d f=%0d nb=%0d v=%0d cnt=%0d last=%0d",
                         $time, x.status, x.found, x.neighbour, x.nb_valid,
                         x.edge_count, x.last);
                $display("%0t: actual   st=%0d f=%0d nb=%0d v=%0d cnt=%0d last=%0d",
                         $time, data[2:0], data[3], data[9:4], data[10], data[19:11], tlast);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // op, node_a, node_b, edge_tag, years_value, zero pad
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // status, found, neighbour, neighbour_valid, edge_count, pad
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    edge_table_sb sb;
    int  idle_cycles;
    int  sent;
    int  small_lim;

    edge_list_table_unit u_dut (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side: random stalls, a few long ones, and checking
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready) sb.check(m_tdata, m_tlast);
            if ($urandom_range(0, 9) < 3)
                m_tready <= 1'b0;
            else if ($urandom_range(0, 49) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(8, 30)) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES)
        begin
            $display("edge_list_table_unit: mismatch");
            $finish;
        end
    end

    // valid drops between items; the block is not ready then anyway
    task automatic send_item(elt_pkg::op_t op, logic [5:0] a, logic [5:0] b,
                             logic [15:0] tag, logic [7:0] years);
        int g;
        g = gap_len();
        repeat (g + 1) @(posedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {2'd0, years, tag, b, a, op};
        do @(posedge clk); while (!s_tready);
        sb.note_op(op, a, b, tag, years);
        sent++;
        s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] addr, logic [31:0] val);
        drain();
        psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_node_count(val[6:0]);
        @(posedge clk);
    endtask

    // mostly small node range so edges collide; some full range
    function automatic logic [5:0] pick_node();
        if ($urandom_range(0, 9) < 8) return 6'($urandom_range(0, small_lim - 1));
        return 6'($urandom_range(0, 63));
    endfunction

    task automatic random_items(int n);
        int r;
        elt_pkg::op_t op;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            op = (r < 40) ? elt_pkg::OP_INSERT : (r < 65) ? elt_pkg::OP_REMOVE :
                 (r < 82) ? elt_pkg::OP_QUERY : elt_pkg::OP_NEIGH;
            send_item(op, pick_node(), pick_node(), 16'($urandom), 8'($urandom));
        end
    endtask

    // stimulus
    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sent = 0;
        small_lim = 8;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, all operations, every status but bad node and full
        send_item(elt_pkg::OP_NEIGH, 6'd5, 6'd0, 16'h0, 8'h0);
        send_item(elt_pkg::OP_INSERT, 6'd0, 6'd63, 16'hFFFF, 8'hFF);
        send_item(elt_pkg::OP_INSERT, 6'd63, 6'd63, 16'h0000, 8'h00);
        send_item(elt_pkg::OP_INSERT, 6'd5, 6'd0, 16'hA5A5, 8'h5A);
        send_item(elt_pkg::OP_INSERT, 6'd5, 6'd0, 16'h5A5A, 8'hA5);
        send_item(elt_pkg::OP_INSERT, 6'd9, 6'd5, 16'h1234, 8'h12);
        send_item(elt_pkg::OP_QUERY, 6'd63, 6'd0, 16'h0, 8'h0);
        send_item(elt_pkg::OP_QUERY, 6'd1, 6'd2, 16'h0, 8'h0);
        send_item(elt_pkg::OP_NEIGH, 6'd5, 6'd63, 16'h0, 8'h0);
        send_item(elt_pkg::OP_NEIGH, 6'd63, 6'd0, 16'h0, 8'h0);
        send_item(elt_pkg::OP_REMOVE, 6'd0, 6'd5, 16'h0, 8'h0);
        send_item(elt_pkg::OP_REMOVE, 6'd1, 6'd2, 16'h0, 8'h0);
        send_item(elt_pkg::OP_REMOVE, 6'd5, 6'd0, 16'h0, 8'h0);
        send_item(elt_pkg::OP_NEIGH, 6'd0, 6'd0, 16'h0, 8'h0);

        // node limit lowered: bad node on insert and neighbours
        write_reg(REG_NODE_COUNT, 32'd10);
        send_item(elt_pkg::OP_INSERT, 6'd10, 6'd1, 16'h1, 8'h1);
        send_item(elt_pkg::OP_INSERT, 6'd1, 6'd10, 16'h1, 8'h1);
        send_item(elt_pkg::OP_NEIGH, 6'd10, 6'd0, 16'h0, 8'h0);
        send_item(elt_pkg::OP_NEIGH, 6'd5, 6'd0, 16'h0, 8'h0);
        send_item(elt_pkg::OP_QUERY, 6'd63, 6'd63, 16'h0, 8'h0);
        send_item(elt_pkg::OP_REMOVE, 6'd63, 6'd63, 16'h0, 8'h0);

        // zero nodes: everything bad; above max is capped
        write_reg(REG_NODE_COUNT, 32'd0);
        send_item(elt_pkg::OP_INSERT, 6'd0, 6'd0, 16'h1, 8'h1);
        send_item(elt_pkg::OP_NEIGH, 6'd0, 6'd0, 16'h0, 8'h0);
        write_reg(REG_NODE_COUNT, 32'd127);
        send_item(elt_pkg::OP_INSERT, 6'd62, 6'd63, 16'h2, 8'h2);
        write_reg(REG_NODE_COUNT, 32'd1);
        send_item(elt_pkg::OP_INSERT, 6'd0, 6'd0, 16'h3, 8'h3);
        send_item(elt_pkg::OP_NEIGH, 6'd0, 6'd0, 16'h0, 8'h0);

        // random: dense small node ranges, and one run over the full range
        write_reg(REG_NODE_COUNT, 32'd64);
        random_items(60);
        drain();
        small_lim = 64;
        random_items(40);
        write_reg(REG_NODE_COUNT, 32'd12);
        small_lim = 12;
        random_items(50);

        // full range again: a neighbour list of a random node and a remove of the oldest entry
        write_reg(REG_NODE_COUNT, 32'd64);
        send_item(elt_pkg::OP_INSERT, 6'd1, 6'd2, 16'h7, 8'h7);
        send_item(elt_pkg::OP_NEIGH, 6'($urandom_range(0, 63)), 6'd0, 16'h0, 8'h0);
        if (sb.edges.size() != 0)
            send_item(elt_pkg::OP_REMOVE, sb.edges[0].a, sb.edges[0].b, 16'h0, 8'h0);
        small_lim = 16;
        random_items(35);

        drain();
        $display("covered %0d items and %0d results over node limits 0,1,10,12,64,127",
                 sent, sb.checked);
        $display("including bad nodes, reversed-only removes and neighbour lists");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("edge_list_table_unit: match");
        else
            $display("edge_list_table_unit: mismatch");
        $finish;
    end

endmodule
